@@ src/efd_pkg.sv @@
// shared types, codes and constants for the escaped frame decoder
// no dependencies; used by efd_crc16, efd_core and the top level
`default_nettype none
package efd_pkg;

  // width of the saturating frame byte counter
  localparam int unsigned LENGTH_BITS = 16;
  localparam logic [LENGTH_BITS-1:0] CNT_MAX = {LENGTH_BITS{1'b1}};

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] REPORT_MAX = 16'hFFFF;

  // frames shorter than this are runts
  localparam logic [LENGTH_BITS-1:0] MIN_FRAME = LENGTH_BITS'(3);

  localparam logic [7:0] START_RESET  = 8'h01;
  localparam logic [7:0] END_RESET    = 8'h04;
  localparam logic [7:0] ESCAPE_RESET = 8'h10;

  // configuration register indexes
  localparam logic [1:0] REG_START  = 2'd0;
  localparam logic [1:0] REG_END    = 2'd1;
  localparam logic [1:0] REG_ESCAPE = 2'd2;

  // status codes
  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_RUNT = 2'd1;
  localparam logic [1:0] STATUS_CRC  = 2'd2;

  // hold line fill levels
  localparam logic [1:0] HOLD_EMPTY = 2'd0;
  localparam logic [1:0] HOLD_ONE   = 2'd1;
  localparam logic [1:0] HOLD_FULL  = 2'd2;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_FRAME = 2'd1,
    MODE_ESC   = 2'd2
  } mode_t;

  typedef struct packed {
    logic [7:0] start_code;
    logic [7:0] end_code;
    logic [7:0] escape_code;
  } codes_t;

  typedef struct packed {
    logic        valid;
    logic [7:0]  out_byte;
    logic        frame_end;
    logic [1:0]  status;
    logic [15:0] frame_length;
  } result_t;

endpackage
`default_nettype wire

@@ src/efd_crc16.sv @@
// one byte step of crc-16, poly 0x1021, msb first
// depends on efd_pkg for the polynomial
`default_nettype none
module efd_crc16 (
  input  wire logic [15:0] crc_in,
  input  wire logic [7:0]  data_in,
  output logic      [15:0] crc_out
);

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {data_in, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ efd_pkg::CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule
`default_nettype wire

@@ src/efd_core.sv @@
// frame state machine, two byte hold line, crc and length tracking
// depends on efd_pkg and efd_crc16
`default_nettype none
module efd_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,
  input  wire logic [7:0]       rx_byte,
  input  wire efd_pkg::codes_t  codes,
  output efd_pkg::result_t      result
);

  efd_pkg::mode_t                    mode_r, mode_nxt;
  logic [7:0]                        hold0_r, hold1_r;
  logic [1:0]                        hold_cnt_r;
  logic [15:0]                       crc_r, crc_step;
  logic [efd_pkg::LENGTH_BITS-1:0]   cnt_r, cnt_inc;

  logic is_esc, is_end, is_start;
  logic take, emit_payload, emit_status;
  logic [31:0] cnt_wide;

  efd_crc16 u_crc (
    .crc_in  (crc_r),
    .data_in (hold0_r),
    .crc_out (crc_step)
  );

  assign is_esc   = (rx_byte == codes.escape_code);
  assign is_end   = (rx_byte == codes.end_code);
  assign is_start = (rx_byte == codes.start_code);

  // escape test comes before the end test inside a frame
  assign take         = ((mode_r == efd_pkg::MODE_FRAME) && !is_esc && !is_end) ||
                        (mode_r == efd_pkg::MODE_ESC);
  assign emit_payload = take && (hold_cnt_r == efd_pkg::HOLD_FULL);
  assign emit_status  = (mode_r == efd_pkg::MODE_FRAME) && !is_esc && is_end;

  assign cnt_inc  = (cnt_r == efd_pkg::CNT_MAX) ? cnt_r : cnt_r + 1'b1;
  assign cnt_wide = 32'(cnt_r);

  // next mode
  always_comb begin
    mode_nxt = mode_r;
    unique case (mode_r)
      efd_pkg::MODE_FRAME: begin
        if (is_esc) begin
          mode_nxt = efd_pkg::MODE_ESC;
        end else if (is_end) begin
          mode_nxt = efd_pkg::MODE_IDLE;
        end
      end
      efd_pkg::MODE_ESC: mode_nxt = efd_pkg::MODE_FRAME;
      default: begin
        mode_nxt = is_start ? efd_pkg::MODE_FRAME : efd_pkg::MODE_IDLE;
      end
    endcase
  end

  // result item
  always_comb begin
    result              = '0;
    result.valid        = step && (emit_payload || emit_status);
    if (emit_status) begin
      result.frame_end  = 1'b1;
      result.frame_length = (cnt_wide > 32'(efd_pkg::REPORT_MAX)) ?
                            efd_pkg::REPORT_MAX : cnt_wide[15:0];
      if (cnt_r < efd_pkg::MIN_FRAME) begin
        result.status   = efd_pkg::STATUS_RUNT;
      end else if (crc_r != {hold1_r, hold0_r}) begin
        result.status   = efd_pkg::STATUS_CRC;
      end else begin
        result.status   = efd_pkg::STATUS_OK;
      end
    end else begin
      result.out_byte   = hold0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= efd_pkg::MODE_IDLE;
      hold0_r    <= '0;
      hold1_r    <= '0;
      hold_cnt_r <= efd_pkg::HOLD_EMPTY;
      crc_r      <= '0;
      cnt_r      <= '0;
    end else if (step) begin
      mode_r <= mode_nxt;
      if ((mode_r != efd_pkg::MODE_FRAME) && (mode_r != efd_pkg::MODE_ESC) && is_start) begin
        hold0_r    <= '0;
        hold1_r    <= '0;
        hold_cnt_r <= efd_pkg::HOLD_EMPTY;
        crc_r      <= '0;
        cnt_r      <= '0;
      end else if (take) begin
        cnt_r <= cnt_inc;
        unique case (hold_cnt_r)
          efd_pkg::HOLD_EMPTY: begin
            hold0_r    <= rx_byte;
            hold_cnt_r <= efd_pkg::HOLD_ONE;
          end
          efd_pkg::HOLD_ONE: begin
            hold1_r    <= rx_byte;
            hold_cnt_r <= efd_pkg::HOLD_FULL;
          end
          default: begin
            // oldest byte leaves the hold line into the crc
            crc_r   <= crc_step;
            hold0_r <= hold1_r;
            hold1_r <= rx_byte;
          end
        endcase
      end
    end
  end

endmodule
`default_nettype wire

@@ src/escaped_frame_decoder_crc16_top.sv @@
// escaped frame decoder with crc-16 check, top level
// a result passes from the input register through efd_core into the output register
// throughput: one item per cycle while out_tready keeps the output register draining,
// set by the single pass through efd_core between the input and output registers
// reset (rst_n low, synchronous): idle mode, empty hold line, codes to 1/4/16
`default_nettype none
module escaped_frame_decoder_crc16_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // rx_byte[7:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // out_byte[7:0], frame_length[23:8]
  output logic             out_tlast,  // frame_end
  output logic [1:0]       out_tuser,  // status[1:0]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  efd_pkg::codes_t  codes_r;
  efd_pkg::result_t result;

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic [1:0] out_status_r;
  logic [15:0] out_len_r;
  logic       advance, step;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codes_r.start_code  <= efd_pkg::START_RESET;
      codes_r.end_code    <= efd_pkg::END_RESET;
      codes_r.escape_code <= efd_pkg::ESCAPE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        efd_pkg::REG_START:  codes_r.start_code  <= cfg_data;
        efd_pkg::REG_END:    codes_r.end_code    <= cfg_data;
        efd_pkg::REG_ESCAPE: codes_r.escape_code <= cfg_data;
        default: ;
      endcase
    end
  end

  // the held item moves on whenever the output register is free or draining
  assign advance   = !out_valid_r || out_tready;
  assign step      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  efd_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (in_byte_r),
    .codes   (codes_r),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte_r   <= result.out_byte;
      out_last_r   <= result.frame_end;
      out_status_r <= result.status;
      out_len_r    <= result.frame_length;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_len_r, out_byte_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_status_r;

endmodule
`default_nettype wire

@@ dv/escaped_frame_decoder_crc16_top_tb.sv @@
// self-checking testbench for escaped_frame_decoder_crc16_top
// drives framed byte streams, predicts payload and frame status items, checks them in order
// depends on efd_pkg and the top level only
`default_nettype none
module escaped_frame_decoder_crc16_top_tb;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int LONG_STALL  = 400;
  localparam int SETTLE      = 8;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        frame_end;
    logic [1:0]  status;
    logic [15:0] frame_length;
  } decoded_t;

  typedef enum int {
    KIND_GOOD,
    KIND_BAD_CRC,
    KIND_NO_CRC,
    KIND_UNCLOSED
  } frame_kind_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tlast;
  logic [1:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = efd_pkg::REG_START;
  logic [7:0]  cfg_data = 8'h00;

  escaped_frame_decoder_crc16_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  logic [7:0]      rx_byte_q[$];
  decoded_t        decoded_q[$];
  int              sender_idle_pct = 0;
  int              recv_idle_pct = 0;
  int              stall_token = 0;
  int              stall_seen = 0;
  int              stall_left = 0;
  int              mismatches = 0;
  int              cycle_count = 0;
  efd_pkg::codes_t gen_codes;

  // predictor state
  efd_pkg::codes_t                 pred_codes;
  efd_pkg::mode_t                  pred_mode;
  logic [7:0]                      held[2];
  logic [1:0]                      held_count;
  logic [15:0]                     crc_acc;
  logic [efd_pkg::LENGTH_BITS-1:0] frame_bytes;

  function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    int i;
    c = crc ^ {b, 8'h00};
    for (i = 0; i < 8; i++)
      c = c[15] ? ((c << 1) ^ efd_pkg::CRC_POLY) : (c << 1);
    return c;
  endfunction

  function automatic void hold_frame_byte(input logic [7:0] b);
    decoded_t r;
    if (frame_bytes != efd_pkg::CNT_MAX) frame_bytes = frame_bytes + 1'b1;
    if (held_count >= efd_pkg::HOLD_FULL) begin
      r = '0;
      r.out_byte = held[0];
      decoded_q.push_back(r);
      crc_acc = crc16_fold(crc_acc, held[0]);
      held[0] = held[1];
      held[1] = b;
    end else begin
      held[held_count[0]] = b;
      held_count = held_count + 1'b1;
    end
  endfunction

  function automatic void decode_rx_byte(input logic [7:0] b);
    decoded_t r;
    if (pred_mode == efd_pkg::MODE_FRAME) begin
      // escape is tested before end, so a clash never closes the frame
      if (b == pred_codes.escape_code) begin
        pred_mode = efd_pkg::MODE_ESC;
      end else if (b == pred_codes.end_code) begin
        pred_mode = efd_pkg::MODE_IDLE;
        r = '0;
        r.frame_end = 1'b1;
        if (frame_bytes < efd_pkg::MIN_FRAME) r.status = efd_pkg::STATUS_RUNT;
        else if (crc_acc != {held[1], held[0]}) r.status = efd_pkg::STATUS_CRC;
        else r.status = efd_pkg::STATUS_OK;
        r.frame_length = (32'(frame_bytes) > 32'(efd_pkg::REPORT_MAX)) ?
                         efd_pkg::REPORT_MAX : 16'(frame_bytes);
        decoded_q.push_back(r);
      end else begin
        hold_frame_byte(b);
      end
    end else if (pred_mode == efd_pkg::MODE_ESC) begin
      pred_mode = efd_pkg::MODE_FRAME;
      hold_frame_byte(b);
    end else begin
      pred_mode = efd_pkg::MODE_IDLE;
      if (b == pred_codes.start_code) begin
        held[0] = 8'h00;
        held[1] = 8'h00;
        held_count = efd_pkg::HOLD_EMPTY;
        crc_acc = 16'h0000;
        frame_bytes = '0;
        pred_mode = efd_pkg::MODE_FRAME;
      end
    end
  endfunction

  // accepted items and register writes feed the predictor
  always @(posedge clk) begin
    if (!rst_n) begin
      pred_codes = {efd_pkg::START_RESET, efd_pkg::END_RESET, efd_pkg::ESCAPE_RESET};
      pred_mode = efd_pkg::MODE_IDLE;
      held[0] = 8'h00;
      held[1] = 8'h00;
      held_count = efd_pkg::HOLD_EMPTY;
      crc_acc = 16'h0000;
      frame_bytes = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          efd_pkg::REG_START:  pred_codes.start_code = cfg_data;
          efd_pkg::REG_END:    pred_codes.end_code = cfg_data;
          efd_pkg::REG_ESCAPE: pred_codes.escape_code = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) decode_rx_byte(in_tdata);
    end
  end

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (rx_byte_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata <= rx_byte_q.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver, with an occasional long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_token != stall_seen) begin
      stall_seen <= stall_token;
      stall_left <= LONG_STALL;
      out_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result check
  always @(posedge clk) begin
    decoded_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (decoded_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item: byte %02h end %0d status %0d len %0d",
                   out_tdata[7:0], out_tlast, out_tuser, out_tdata[23:8]);
      end else begin
        want = decoded_q.pop_front();
        if (want.out_byte != out_tdata[7:0] || want.frame_end != out_tlast ||
            want.status != out_tuser || want.frame_length != out_tdata[23:8]) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected byte %02h end %0d status %0d len %0d,",
                      " got byte %02h end %0d status %0d len %0d"},
                     want.out_byte, want.frame_end, want.status, want.frame_length,
                     out_tdata[7:0], out_tlast, out_tuser, out_tdata[23:8]);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("escaped_frame_decoder_crc16_top_tb: errors");
      $finish;
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0: return gen_codes.start_code;
      1: return gen_codes.end_code;
      2: return gen_codes.escape_code;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic void push_escaped(input logic [7:0] b);
    if (b == gen_codes.end_code || b == gen_codes.escape_code)
      rx_byte_q.push_back(gen_codes.escape_code);
    rx_byte_q.push_back(b);
  endfunction

  function automatic void queue_payload_frame(input logic [7:0] body[$],
                                              input frame_kind_t kind);
    logic [15:0] crc;
    crc = 16'h0000;
    rx_byte_q.push_back(gen_codes.start_code);
    foreach (body[i]) begin
      push_escaped(body[i]);
      crc = crc16_fold(crc, body[i]);
    end
    if (kind != KIND_NO_CRC) begin
      if (kind == KIND_BAD_CRC) crc = crc ^ (16'h0001 << $urandom_range(15));
      push_escaped(crc[7:0]);
      push_escaped(crc[15:8]);
    end
    if (kind != KIND_UNCLOSED) rx_byte_q.push_back(gen_codes.end_code);
  endfunction

  function automatic void queue_frame(input int len, input frame_kind_t kind);
    logic [7:0] body[$];
    int i;
    for (i = 0; i < len; i++) body.push_back(pick_byte());
    queue_payload_frame(body, kind);
  endfunction

  // mostly well-formed frames, some runts, broken frames and line noise
  function automatic void queue_random(input int count);
    int target;
    int r;
    int i;
    target = rx_byte_q.size() + count;
    while (rx_byte_q.size() < target) begin
      r = $urandom_range(99);
      if (r < 60) begin
        queue_frame($urandom_range(12), KIND_GOOD);
      end else if (r < 75) begin
        queue_frame($urandom_range(12), KIND_BAD_CRC);
      end else if (r < 83) begin
        queue_frame($urandom_range(3), KIND_NO_CRC);
      end else if (r < 88) begin
        queue_frame($urandom_range(6), KIND_UNCLOSED);
      end else if (r < 94) begin
        for (i = $urandom_range(1, 4); i > 0; i--)
          rx_byte_q.push_back(8'($urandom_range(255)));
      end else begin
        // escaped end code inside the frame, then the real end
        rx_byte_q.push_back(gen_codes.start_code);
        for (i = $urandom_range(0, 3); i > 0; i--) push_escaped(pick_byte());
        rx_byte_q.push_back(gen_codes.escape_code);
        rx_byte_q.push_back(gen_codes.end_code);
        for (i = $urandom_range(0, 3); i > 0; i--) push_escaped(pick_byte());
        rx_byte_q.push_back(gen_codes.end_code);
      end
    end
  endfunction

  task automatic wait_drained();
    while (rx_byte_q.size() != 0 || in_tvalid || decoded_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    // the last item may have left the queue on the edge the loop above ended
    while (decoded_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_codes(input logic [7:0] s, input logic [7:0] e, input logic [7:0] x);
    wait_drained();
    write_reg(efd_pkg::REG_START, s);
    write_reg(efd_pkg::REG_END, e);
    write_reg(efd_pkg::REG_ESCAPE, x);
    cfg_valid <= 1'b0;
    gen_codes = {s, e, x};
  endtask

  initial begin
    logic [7:0] body[$];
    gen_codes = {efd_pkg::START_RESET, efd_pkg::END_RESET, efd_pkg::ESCAPE_RESET};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: noise while idle, runts of every size, code bytes as payload, bad crc
    sender_idle_pct = 19;
    recv_idle_pct = 69;
    rx_byte_q.push_back(8'h00);
    rx_byte_q.push_back(8'hFF);
    rx_byte_q.push_back(efd_pkg::END_RESET);
    queue_frame(0, KIND_NO_CRC);
    body = '{8'hAA};
    queue_payload_frame(body, KIND_NO_CRC);
    body = '{8'h00, 8'hFF};
    queue_payload_frame(body, KIND_NO_CRC);
    body = '{efd_pkg::END_RESET, efd_pkg::ESCAPE_RESET, efd_pkg::START_RESET};
    queue_payload_frame(body, KIND_GOOD);
    body = '{8'h80};
    queue_payload_frame(body, KIND_BAD_CRC);
    wait_drained();

    // random with default codes, one long hold-off so the input backs up
    queue_random(600);
    stall_token++;
    load_codes(8'h00, 8'hFF, 8'h80);

    sender_idle_pct = 69;
    recv_idle_pct = 19;
    queue_random(550);
    load_codes(8'hFF, 8'h00, 8'h7F);

    sender_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(400);
    // escape equal to end: frames cannot close
    load_codes(8'h55, 8'hAA, 8'hAA);
    sender_idle_pct = 19;
    recv_idle_pct = 69;
    queue_random(100);
    // start equal to end
    load_codes(8'hAA, 8'hAA, 8'h55);
    queue_random(150);

    load_codes(efd_pkg::START_RESET, efd_pkg::END_RESET, efd_pkg::ESCAPE_RESET);
    sender_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(50);
    wait_drained();

    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("escaped_frame_decoder_crc16_top_tb: clean");
    end else begin
      $display("escaped_frame_decoder_crc16_top_tb: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
